>>> hdl/tpeq_pkg.sv
// ----------------------------------------------------------------------------
// tpeq_pkg: shared types and constants of the timed priority event queue
// Holds the stored event record, the status codes, the controller states
// and the command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package tpeq_pkg;

  localparam int unsigned CapacityDef = 16;
  localparam int unsigned TickW       = 32;
  localparam int unsigned PrioW       = 8;
  localparam int unsigned TypeW       = 16;
  localparam int unsigned SubjW       = 32;
  localparam int unsigned PayW        = 16;
  localparam int unsigned SeqW        = 32;
  localparam int unsigned PendW       = 5;
  localparam int unsigned StatW       = 2;
  localparam int unsigned InDataW     = 104;
  localparam int unsigned OutDataW    = 144;

  typedef enum logic [StatW-1:0] {
    ST_SCHEDULED = 2'd0,
    ST_REFUSED   = 2'd1,
    ST_DUE       = 2'd2,
    ST_NONE      = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PUB,
    S_SCAN,
    S_DECIDE
  } state_e;

  typedef struct packed {
    logic [TickW-1:0]        tick;
    logic signed [PrioW-1:0] prio;
    logic [SeqW-1:0]         seq;
    logic [TypeW-1:0]        etype;
    logic [SubjW-1:0]        subj;
    logic [PayW-1:0]         pay;
  } entry_t;

  // controller -> datapath
  typedef struct packed {
    logic latch;     // take the input transaction
    logic publish;   // store or refuse the held event, load the result
    logic step;      // examine one slot during the scan
    logic emit;      // load the best due event or the none result
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_drain;
    logic scan_last;
    logic out_free;
    logic emit_last;
  } stat_t;

endpackage

>>> hdl/tpeq_ctrl.sv
// ----------------------------------------------------------------------------
// tpeq_ctrl: sequencer of the timed priority event queue
// Steps publishes through a publish phase and drains through scan and emit phases.
// ----------------------------------------------------------------------------
module tpeq_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_valid_i,
  output logic            s_ready_o,
  input  tpeq_pkg::stat_t st_i,
  output tpeq_pkg::cmd_t  cmd_o
);

  tpeq_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tpeq_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      tpeq_pkg::S_IDLE: begin
        if (s_valid_i) begin
          state_d = st_i.is_drain ? tpeq_pkg::S_SCAN : tpeq_pkg::S_PUB;
        end
      end
      tpeq_pkg::S_PUB: begin
        if (st_i.out_free) state_d = tpeq_pkg::S_IDLE;
      end
      tpeq_pkg::S_SCAN: begin
        if (st_i.scan_last) state_d = tpeq_pkg::S_DECIDE;
      end
      tpeq_pkg::S_DECIDE: begin
        if (st_i.out_free) begin
          state_d = st_i.emit_last ? tpeq_pkg::S_IDLE : tpeq_pkg::S_SCAN;
        end
      end
      default: state_d = tpeq_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    s_ready_o     = 1'b0;
    cmd_o         = '0;
    case (state_q)
      tpeq_pkg::S_IDLE: begin
        s_ready_o = 1'b1;
        cmd_o.latch = s_valid_i;
      end
      tpeq_pkg::S_PUB:    cmd_o.publish = st_i.out_free;
      tpeq_pkg::S_SCAN:   cmd_o.step = 1'b1;
      tpeq_pkg::S_DECIDE: cmd_o.emit = st_i.out_free;
      default: ;
    endcase
  end

endmodule

>>> hdl/tpeq_dp.sv
// ----------------------------------------------------------------------------
// tpeq_dp: event store, scan unit and result register
// Scans one slot a cycle for the best due event and holds one result.
// ----------------------------------------------------------------------------
module tpeq_dp #(
  parameter int unsigned CAPACITY = tpeq_pkg::CapacityDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_kind_i,
  input  logic [tpeq_pkg::InDataW-1:0]    in_data_i,
  input  tpeq_pkg::cmd_t                  cmd_i,
  output tpeq_pkg::stat_t                 st_o,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [tpeq_pkg::OutDataW-1:0]   out_data_o,
  output logic [tpeq_pkg::StatW-1:0]      out_user_o,
  output logic                            out_last_o
);

  localparam int unsigned IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam logic [IdxW-1:0] IdxLast = IdxW'(CAPACITY - 1);

  tpeq_pkg::entry_t        entry_q [CAPACITY];
  logic [CAPACITY-1:0]     valid_q, valid_d;
  logic [CntW-1:0]         count_q, count_d;
  logic [tpeq_pkg::SeqW-1:0] next_seq_q;

  // held input transaction
  logic                    kind_q;
  tpeq_pkg::entry_t        req_q;

  // scan state
  logic [IdxW-1:0]         idx_q;
  logic [IdxW-1:0]         best_q;
  logic                    best_vld_q;
  logic [CntW-1:0]         due_q;
  tpeq_pkg::entry_t        best_e_q;

  // result register
  logic                    out_valid_q;
  tpeq_pkg::entry_t        out_e_q;
  logic [tpeq_pkg::StatW-1:0] out_stat_q;
  logic [CntW-1:0]         out_pend_q;
  logic                    out_last_q;

  tpeq_pkg::entry_t        cand;
  logic                    cand_due, cand_first;
  logic [IdxW-1:0]         free_idx;
  logic                    refuse;
  tpeq_pkg::entry_t        pub_e, pub_res;

  assign cand     = entry_q[idx_q];
  assign cand_due = valid_q[idx_q] && (cand.tick <= req_q.tick);
  always_comb begin
    if (cand.tick != best_e_q.tick) cand_first = cand.tick < best_e_q.tick;
    else if (cand.prio != best_e_q.prio) cand_first = cand.prio > best_e_q.prio;
    else cand_first = cand.seq < best_e_q.seq;
  end

  // lowest free slot
  always_comb begin
    free_idx = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (!valid_q[i]) free_idx = IdxW'(i);
    end
  end
  assign refuse = (&valid_q) || (next_seq_q == '0);

  // stored record and scheduled result of a publish
  always_comb begin
    pub_e       = req_q;
    pub_e.seq   = next_seq_q;
    pub_res     = '0;
    pub_res.seq = next_seq_q;
  end

  assign st_o.is_drain  = in_kind_i;
  assign st_o.scan_last = (idx_q == IdxLast);
  assign st_o.out_free  = !out_valid_q || out_ready_i;
  assign st_o.emit_last = !best_vld_q || (due_q == CntW'(1));

  always_comb begin
    valid_d = valid_q;
    count_d = count_q;
    if (cmd_i.publish && !refuse) begin
      valid_d[free_idx] = 1'b1;
      count_d = count_q + CntW'(1);
    end else if (cmd_i.emit && best_vld_q) begin
      valid_d[best_q] = 1'b0;
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      count_q     <= '0;
      next_seq_q  <= tpeq_pkg::SeqW'(1);
      out_valid_q <= 1'b0;
      idx_q       <= '0;
      best_vld_q  <= 1'b0;
      due_q       <= '0;
    end else begin
      valid_q <= valid_d;
      count_q <= count_d;
      if (cmd_i.publish && !refuse) next_seq_q <= next_seq_q + tpeq_pkg::SeqW'(1);
      if (cmd_i.publish || cmd_i.emit) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      // restart the scan after each transaction or emission
      if (cmd_i.latch || cmd_i.emit) begin
        idx_q      <= '0;
        best_vld_q <= 1'b0;
        due_q      <= '0;
      end else if (cmd_i.step) begin
        idx_q <= idx_q + IdxW'(1);
        if (cand_due) begin
          due_q <= due_q + CntW'(1);
          if (!best_vld_q || cand_first) best_vld_q <= 1'b1;
        end
      end
    end
  end

  // payload storage
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      kind_q      <= in_kind_i;
      req_q.tick  <= in_data_i[31:0];
      req_q.prio  <= in_data_i[39:32];
      req_q.etype <= in_data_i[55:40];
      req_q.subj  <= in_data_i[87:56];
      req_q.pay   <= in_data_i[103:88];
      req_q.seq   <= '0;
    end
    if (cmd_i.step && cand_due && (!best_vld_q || cand_first)) begin
      best_q   <= idx_q;
      best_e_q <= cand;
    end
    if (cmd_i.publish) begin
      out_last_q <= 1'b1;
      if (refuse) begin
        out_e_q    <= '0;
        out_stat_q <= tpeq_pkg::ST_REFUSED;
        out_pend_q <= count_q;
      end else begin
        entry_q[free_idx] <= pub_e;
        out_e_q     <= pub_res;
        out_stat_q  <= tpeq_pkg::ST_SCHEDULED;
        out_pend_q  <= count_q + CntW'(1);
      end
    end else if (cmd_i.emit) begin
      out_last_q <= st_o.emit_last;
      out_pend_q <= count_d;
      if (best_vld_q) begin
        out_e_q    <= best_e_q;
        out_stat_q <= tpeq_pkg::ST_DUE;
      end else begin
        out_e_q    <= '0;
        out_stat_q <= tpeq_pkg::ST_NONE;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_user_o  = out_stat_q;
  assign out_last_o  = out_last_q;
  assign out_data_o  = {3'b000, tpeq_pkg::PendW'(out_pend_q), out_e_q.pay, out_e_q.subj,
                        out_e_q.etype, out_e_q.prio, out_e_q.tick, out_e_q.seq};

  a_count_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CntW'($countones(valid_q)) == count_q) else $error("count out of step");
  a_emit_drops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit && best_vld_q) |=> count_q == $past(count_q) - CntW'(1))
    else $error("emit did not remove entry");
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !(cmd_i.publish || cmd_i.emit))
    else $error("result overwritten");
  a_kind_use: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.publish |-> !kind_q) else $error("publish on drain");

endmodule

>>> hdl/timed_priority_event_queue.sv
// ----------------------------------------------------------------------------
// timed_priority_event_queue: store of scheduled events drained by tick
// Publish stores an event with a fresh sequence number or refuses it; drain emits every
// event due at the given tick in tick, priority, sequence order, or a none result.
//
//   channel  dir  tdata                                   tuser      tlast
//   s_axis   in   tick, priority_req, event_type,         kind       -
//                 subject, payload_handle
//   m_axis   out  sequence_res, due_tick, due_priority,   status     last
//                 due_type, due_subject, due_payload,
//                 pending_count
//
// Publish: the result is registered once the output is free, then input is taken again.
// Drain: each emitted event takes a scan of the store, one slot a cycle, then a
// decide state that registers the result once the output is free.
// One transaction is worked on at a time; input is taken only when idle.
// Reset empties the store at once and sets the next sequence to one.
// A stalled result holds the datapath until the transaction is taken.
// ----------------------------------------------------------------------------
module timed_priority_event_queue #(
  parameter int unsigned CAPACITY = tpeq_pkg::CapacityDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // [31:0] tick, [39:32] priority_req, [55:40] event_type,
  // [87:56] subject, [103:88] payload_handle
  input  logic [tpeq_pkg::InDataW-1:0]  s_axis_tdata_i,
  // [0] kind
  input  logic                          s_axis_tuser_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // [31:0] sequence_res, [63:32] due_tick, [71:64] due_priority,
  // [87:72] due_type, [119:88] due_subject, [135:120] due_payload,
  // [140:136] pending_count, rest zero
  output logic [tpeq_pkg::OutDataW-1:0] m_axis_tdata_o,
  // [1:0] status
  output logic [tpeq_pkg::StatW-1:0]    m_axis_tuser_o,
  output logic                          m_axis_tlast_o
);

  tpeq_pkg::cmd_t  cmd;
  tpeq_pkg::stat_t st;

  // sequencer: idle, publish, scan, decide
  tpeq_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .st_i      (st),
    .cmd_o     (cmd)
  );

  // store, scan unit and output register
  tpeq_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_kind_i   (s_axis_tuser_i),
    .in_data_i   (s_axis_tdata_i),
    .cmd_i       (cmd),
    .st_o        (st),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o),
    .out_user_o  (m_axis_tuser_o),
    .out_last_o  (m_axis_tlast_o)
  );

endmodule

>>> test/timed_priority_event_queue_checker.sv
// ----------------------------------------------------------------------------
// timed_priority_event_queue_checker: result predictor and scoreboard
// Watches both stream channels, keeps a private copy of the event store,
// predicts every result of each accepted transaction and compares them.
// ----------------------------------------------------------------------------
module timed_priority_event_queue_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  input  logic                           s_axis_tready_i,
  input  logic [tpeq_pkg::InDataW-1:0]   s_axis_tdata_i,
  input  logic                           s_axis_tuser_i,
  input  logic                           m_axis_tvalid_i,
  input  logic                           m_axis_tready_i,
  input  logic [tpeq_pkg::OutDataW-1:0]  m_axis_tdata_i,
  input  logic [tpeq_pkg::StatW-1:0]     m_axis_tuser_i,
  input  logic                           m_axis_tlast_i,
  output int                             fail_count_o,
  output int                             waiting_o
);

  localparam int Slots = tpeq_pkg::CapacityDef;

  typedef struct packed {
    tpeq_pkg::status_e                 status;
    logic [tpeq_pkg::SeqW-1:0]         seq;
    logic [tpeq_pkg::TickW-1:0]        tick;
    logic signed [tpeq_pkg::PrioW-1:0] prio;
    logic [tpeq_pkg::TypeW-1:0]        etype;
    logic [tpeq_pkg::SubjW-1:0]        subj;
    logic [tpeq_pkg::PayW-1:0]         pay;
    logic [tpeq_pkg::PendW-1:0]        pending;
    logic                              last;
  } event_result_t;

  logic                      slot_used [Slots];
  tpeq_pkg::entry_t          slot_event [Slots];
  logic [tpeq_pkg::SeqW-1:0] seq_counter;
  event_result_t             due_results [$];

  assign waiting_o = due_results.size();

  function automatic int used_slots();
    int n;
    n = 0;
    for (int i = 0; i < Slots; i++) if (slot_used[i]) n++;
    return n;
  endfunction

  // Append one predicted result at the tail.
  function automatic void enqueue_result(event_result_t r);
    due_results = {due_results, r};
  endfunction

  // True when event a leaves the store ahead of event b.
  function automatic bit ahead_of(tpeq_pkg::entry_t a, tpeq_pkg::entry_t b);
    if (a.tick != b.tick) return a.tick < b.tick;
    if (a.prio != b.prio) return a.prio > b.prio;
    return a.seq < b.seq;
  endfunction

  task automatic predict_transaction(logic drain, logic [tpeq_pkg::InDataW-1:0] d);
    event_result_t r;
    int free_idx, best, pend, due;
    r = '0;
    pend = used_slots();
    r.pending = pend[tpeq_pkg::PendW-1:0];
    r.last = 1'b1;
    if (!drain) begin
      free_idx = -1;
      for (int i = Slots - 1; i >= 0; i--) if (!slot_used[i]) free_idx = i;
      if (free_idx < 0 || seq_counter == '0) begin
        r.status = tpeq_pkg::ST_REFUSED;
      end else begin
        slot_used[free_idx] = 1'b1;
        slot_event[free_idx].tick  = d[31:0];
        slot_event[free_idx].prio  = d[39:32];
        slot_event[free_idx].etype = d[55:40];
        slot_event[free_idx].subj  = d[87:56];
        slot_event[free_idx].pay   = d[103:88];
        slot_event[free_idx].seq   = seq_counter;
        r.status  = tpeq_pkg::ST_SCHEDULED;
        r.seq     = seq_counter;
        r.pending = tpeq_pkg::PendW'(pend + 1);
        seq_counter++;
      end
      enqueue_result(r);
    end else begin
      due = 0;
      for (int i = 0; i < Slots; i++)
        if (slot_used[i] && slot_event[i].tick <= d[31:0]) due++;
      if (due == 0) begin
        r.status = tpeq_pkg::ST_NONE;
        enqueue_result(r);
      end
      while (due > 0) begin
        best = -1;
        for (int i = 0; i < Slots; i++)
          if (slot_used[i] && slot_event[i].tick <= d[31:0])
            if (best < 0 || ahead_of(slot_event[i], slot_event[best])) best = i;
        slot_used[best] = 1'b0;
        pend--;
        due--;
        r.status  = tpeq_pkg::ST_DUE;
        r.seq     = slot_event[best].seq;
        r.tick    = slot_event[best].tick;
        r.prio    = slot_event[best].prio;
        r.etype   = slot_event[best].etype;
        r.subj    = slot_event[best].subj;
        r.pay     = slot_event[best].pay;
        r.pending = pend[tpeq_pkg::PendW-1:0];
        r.last    = (due == 0);
        enqueue_result(r);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    event_result_t got, exp_r;
    if (!rst_ni) begin
      for (int i = 0; i < Slots; i++) slot_used[i] = 1'b0;
      seq_counter = 1;
      due_results.delete();
      fail_count_o = 0;
    end else begin
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got.status  = tpeq_pkg::status_e'(m_axis_tuser_i);
        got.seq     = m_axis_tdata_i[31:0];
        got.tick    = m_axis_tdata_i[63:32];
        got.prio    = m_axis_tdata_i[71:64];
        got.etype   = m_axis_tdata_i[87:72];
        got.subj    = m_axis_tdata_i[119:88];
        got.pay     = m_axis_tdata_i[135:120];
        got.pending = m_axis_tdata_i[140:136];
        got.last    = m_axis_tlast_i;
        if (due_results.size() == 0) begin
          $display("%0t: unexpected result %p", $time, got);
          fail_count_o++;
        end else begin
          exp_r = due_results.pop_front();
          if (got !== exp_r || m_axis_tdata_i[tpeq_pkg::OutDataW-1:141] !== '0) begin
            $display("%0t: mismatch expected %p actual %p", $time, exp_r, got);
            fail_count_o++;
          end
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i)
        predict_transaction(s_axis_tuser_i, s_axis_tdata_i);
    end
  end

endmodule

>>> test/timed_priority_event_queue_tb.sv
// ----------------------------------------------------------------------------
// timed_priority_event_queue_tb: stimulus and verdict for the event queue
// Drives directed and random publish and drain transactions with bursty
// input and a stalling receiver; the checker predicts and compares.
// ----------------------------------------------------------------------------
module timed_priority_event_queue_tb;

  localparam int StallLimit = 20000;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          s_axis_tvalid_i;
  logic                          s_axis_tready_o;
  logic [tpeq_pkg::InDataW-1:0]  s_axis_tdata_i;
  logic                          s_axis_tuser_i;
  logic                          m_axis_tvalid_o;
  logic                          m_axis_tready_i;
  logic [tpeq_pkg::OutDataW-1:0] m_axis_tdata_o;
  logic [tpeq_pkg::StatW-1:0]    m_axis_tuser_o;
  logic                          m_axis_tlast_o;
  int                            fail_count;
  int                            waiting;
  int                            idle_cycles = 0;
  int                            stall_mode = 0;
  int                            burst_left;

  timed_priority_event_queue dut (.*);

  timed_priority_event_queue_checker checker_i (
    .clk_i, .rst_ni, .s_axis_tvalid_i,
    .s_axis_tready_i(s_axis_tready_o),
    .s_axis_tdata_i, .s_axis_tuser_i,
    .m_axis_tvalid_i(m_axis_tvalid_o), .m_axis_tready_i,
    .m_axis_tdata_i(m_axis_tdata_o), .m_axis_tuser_i(m_axis_tuser_o),
    .m_axis_tlast_i(m_axis_tlast_o),
    .fail_count_o(fail_count), .waiting_o(waiting)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Receiver stalls in phases: always ready, random, or mostly stalled.
  always @(posedge clk_i) begin
    if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: m_axis_tready_i <= 1'b1;
      1: m_axis_tready_i <= 1'($urandom_range(0, 1));
      default: m_axis_tready_i <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > StallLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Send one transaction, with a random gap when a burst runs out.
  task automatic send(logic drain, logic [31:0] tick, logic [7:0] prio,
                      logic [15:0] etype, logic [31:0] subj, logic [15:0] pay);
    if (burst_left == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = $urandom_range(1, 10);
    end
    burst_left--;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= drain;
    s_axis_tdata_i  <= {pay, subj, etype, prio, tick};
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  task automatic publish_rand(logic [31:0] tick);
    send(1'b0, tick, 8'($urandom), 16'($urandom), $urandom, 16'($urandom));
  endtask

  initial begin
    logic [31:0] now;
    int n;
    rst_ni = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tuser_i = 1'b0;
    s_axis_tdata_i = '0;
    burst_left = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: drain of an empty store, field extremes, ties, full store.
    send(1'b1, 32'hFFFF_FFFF, 8'h0, 16'h0, 32'h0, 16'h0);
    send(1'b0, 32'h0, 8'h80, 16'h0, 32'h0, 16'h0);
    send(1'b0, 32'hFFFF_FFFF, 8'h7F, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
    send(1'b0, 32'd5, 8'h7F, 16'h1, 32'h1, 16'h1);
    send(1'b0, 32'd5, 8'h80, 16'h2, 32'h2, 16'h2);
    send(1'b0, 32'd5, 8'h7F, 16'h3, 32'h3, 16'h3);
    send(1'b1, 32'd4, 8'h0, 16'h0, 32'h0, 16'h0);
    send(1'b1, 32'd5, 8'h0, 16'h0, 32'h0, 16'h0);
    for (int i = 0; i < 15; i++) publish_rand($urandom_range(0, 9));
    send(1'b0, 32'd1, 8'h01, 16'hAAAA, 32'h5555_AAAA, 16'h5555);
    send(1'b1, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);

    // Hold off until every expected result is in.
    s_axis_tvalid_i <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    wait (waiting == 0);

    // Random: mostly publish runs followed by a drain at an advancing tick.
    now = 0;
    n = 0;
    while (n < 320) begin
      if ($urandom_range(0, 3) == 0) begin
        send(1'b1, $urandom_range(0, 3) == 0 ? $urandom : now, 8'($urandom),
             16'($urandom), $urandom, 16'($urandom));
        now += $urandom_range(0, 6);
      end else if ($urandom_range(0, 9) == 0) begin
        publish_rand($urandom);
      end else begin
        publish_rand(now + $urandom_range(0, 8));
      end
      n++;
    end
    send(1'b1, 32'hFFFF_FFFF, 8'h0, 16'h0, 32'h0, 16'h0);
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);

    wait (waiting == 0);
    repeat (40) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> timed_priority_event_queue.f
hdl/tpeq_pkg.sv
hdl/tpeq_ctrl.sv
hdl/tpeq_dp.sv
hdl/timed_priority_event_queue.sv
test/timed_priority_event_queue_checker.sv
test/timed_priority_event_queue_tb.sv
